/* rtl/mf3_pkg.sv */
// ----------------------------------------------------------------------------
// Median filter 3x3 package
// Shared widths, register indexes and beat types of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int PIXEL_BITS  = 8;
  localparam int COL_BITS    = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS    = 16;
  localparam int CFG_BITS    = 16;
  localparam int WIN_SIZE    = 9;
  localparam int WIN_MID     = 4;

  localparam logic [COL_BITS:0]   COLUMNS_RESET = (COL_BITS + 1)'(640);
  localparam logic [ROW_BITS-1:0] ROWS_RESET    = ROW_BITS'(480);

  localparam logic [0:0] CFG_COLUMNS = 1'b0;
  localparam logic [0:0] CFG_ROWS    = 1'b1;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef pixel_t [WIN_SIZE-1:0] win_t;

  typedef struct packed {
    pixel_t pixel_value;
    logic   frame_start;
  } in_beat_t;

  typedef struct packed {
    pixel_t                median_value;
    logic [ROW_BITS-1:0]   center_row;
    logic [COL_BITS-1:0]   center_col;
    logic                  frame_last;
  } out_beat_t;

  typedef struct packed {
    logic                  produce;
    logic [ROW_BITS-1:0]   row;
    logic [COL_BITS-1:0]   col;
    logic                  last;
  } tag_t;

endpackage

/* rtl/mf3_sort_cell.sv */
// ----------------------------------------------------------------------------
// Median filter sort cell
// One odd-even transposition step over the nine window pixels, registered.
// ----------------------------------------------------------------------------
module mf3_sort_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           odd_phase,
  input  logic           valid_in,
  input  mf3_pkg::win_t  win_in,
  input  mf3_pkg::tag_t  tag_in,
  output logic           valid_r,
  output mf3_pkg::win_t  win_r,
  output mf3_pkg::tag_t  tag_r
);

  mf3_pkg::win_t win_nxt;

  always_comb begin
    win_nxt = win_in;
    for (int i = 0; i < mf3_pkg::WIN_SIZE - 1; i++) begin
      if (i[0] == odd_phase) begin
        if (win_in[i] > win_in[i+1]) begin
          win_nxt[i]   = win_in[i+1];
          win_nxt[i+1] = win_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    tag_r <= tag_in;
  end

endmodule

/* rtl/mf3_window.sv */
// ----------------------------------------------------------------------------
// Median filter window
// Raster counters, geometry registers, two line stores and the 3x3 window.
// ----------------------------------------------------------------------------
module mf3_window (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  mf3_pkg::in_beat_t                in_data,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_index,
  input  logic [mf3_pkg::CFG_BITS-1:0]     cfg_data,
  output logic                             win_valid_r,
  output mf3_pkg::win_t                    win_r,
  output mf3_pkg::tag_t                    win_tag_r
);

  localparam int CB = mf3_pkg::COL_BITS;
  localparam int RB = mf3_pkg::ROW_BITS;

  logic [CB:0]   cols_cfg_r;
  logic [RB-1:0] rows_cfg_r;
  logic [CB-1:0] col_r, col_nxt;
  logic [RB-1:0] row_r, row_nxt;

  logic [CB:0]   cols;
  logic [RB-1:0] rows;
  logic [CB-1:0] c;
  logic [RB-1:0] r;
  logic          col_end;
  logic          row_end;
  mf3_pkg::tag_t tag;

  mf3_pkg::pixel_t upper_mem [mf3_pkg::MAX_COLUMNS];
  mf3_pkg::pixel_t middle_mem [mf3_pkg::MAX_COLUMNS];

  logic            s1_valid_r;
  logic [CB-1:0]   s1_col_r;
  mf3_pkg::pixel_t s1_pix_r;
  mf3_pkg::tag_t   s1_tag_r;
  mf3_pkg::pixel_t upper_q_r;
  mf3_pkg::pixel_t middle_q_r;
  logic            fwd_r;
  mf3_pkg::pixel_t fwd_val_r;
  mf3_pkg::pixel_t top;
  mf3_pkg::win_t   win_nxt;

  always_comb begin
    if (cols_cfg_r < (CB + 1)'(3)) begin
      cols = (CB + 1)'(3);
    end else if (cols_cfg_r > (CB + 1)'(mf3_pkg::MAX_COLUMNS)) begin
      cols = (CB + 1)'(mf3_pkg::MAX_COLUMNS);
    end else begin
      cols = cols_cfg_r;
    end
    rows = (rows_cfg_r < RB'(3)) ? RB'(3) : rows_cfg_r;

    c = in_data.frame_start ? '0 : col_r;
    r = in_data.frame_start ? '0 : row_r;
    if ({1'b0, c} >= cols) begin
      c = '0;
    end
    if (r >= rows) begin
      r = '0;
    end

    col_end = ({1'b0, c} + (CB + 1)'(1)) >= cols;
    row_end = ({1'b0, r} + (RB + 1)'(1)) >= {1'b0, rows};

    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : r + RB'(1);
    end else begin
      col_nxt = c + CB'(1);
      row_nxt = r;
    end

    tag.produce = (r >= RB'(2)) && (c >= CB'(2));
    tag.row     = r - RB'(1);
    tag.col     = c - CB'(1);
    tag.last    = col_end && row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= mf3_pkg::COLUMNS_RESET;
      rows_cfg_r <= mf3_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mf3_pkg::CFG_COLUMNS: cols_cfg_r <= cfg_data[CB:0];
        mf3_pkg::CFG_ROWS:    rows_cfg_r <= cfg_data[RB-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      win_valid_r <= 1'b0;
      win_r       <= '0;
    end else begin
      s1_valid_r  <= accept;
      win_valid_r <= s1_valid_r;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        fwd_r <= s1_valid_r && (s1_col_r == c);
      end
      if (s1_valid_r) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      upper_q_r     <= upper_mem[c];
      middle_q_r    <= middle_mem[c];
      middle_mem[c] <= in_data.pixel_value;
      s1_col_r      <= c;
      s1_pix_r      <= in_data.pixel_value;
      s1_tag_r      <= tag;
      fwd_val_r     <= middle_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      upper_mem[s1_col_r] <= middle_q_r;
      win_tag_r           <= s1_tag_r;
    end
  end

  assign top = fwd_r ? fwd_val_r : upper_q_r;

  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = top;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = middle_q_r;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_pix_r;
  end

endmodule

/* rtl/median_filter_3x3.sv */
// ----------------------------------------------------------------------------
// Median filter 3x3
// Streaming 3x3 median filter over a grayscale raster with two line stores.
//
//   Channel   Ports                          Direction  Beat
//   input     in_valid  in_stall  in_data    in         one raster pixel
//   result    out_valid out_stall out_data   out        one interior median
//   config    cfg_we    cfg_index cfg_data   in         one register write
//
// One pixel beat is taken every cycle while in_stall is low; each pixel passes
// through the window stage and a chain of nine sort cells before its result leaves.
// A 16-entry output queue absorbs results while out_stall is high; in_stall
// rises only when 16 beats are held between input and output.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module median_filter_3x3 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mf3_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mf3_pkg::out_beat_t            out_data,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [mf3_pkg::CFG_BITS-1:0]  cfg_data
);

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CHAIN      = mf3_pkg::WIN_SIZE;

  logic                  accept;
  logic                  pop;
  logic                  push;
  logic                  drop;

  logic                  chain_valid [CHAIN+1];
  mf3_pkg::win_t         chain_win   [CHAIN+1];
  mf3_pkg::tag_t         chain_tag   [CHAIN+1];

  mf3_pkg::out_beat_t    fifo_mem [FIFO_DEPTH];
  mf3_pkg::out_beat_t    push_beat;
  logic [FIFO_AW-1:0]    wr_ptr_r;
  logic [FIFO_AW-1:0]    rd_ptr_r;
  logic [FIFO_AW:0]      fifo_cnt_r;
  logic [FIFO_AW:0]      occ_r;
  logic [FIFO_AW:0]      occ_nxt;

  assign accept = in_valid && !in_stall;
  assign in_stall = (occ_r == (FIFO_AW + 1)'(FIFO_DEPTH));

  mf3_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_data     (in_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .win_valid_r (chain_valid[0]),
    .win_r       (chain_win[0]),
    .win_tag_r   (chain_tag[0])
  );

  for (genvar k = 0; k < CHAIN; k++) begin : g_cell
    mf3_sort_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .odd_phase (1'(k % 2)),
      .valid_in  (chain_valid[k]),
      .win_in    (chain_win[k]),
      .tag_in    (chain_tag[k]),
      .valid_r   (chain_valid[k+1]),
      .win_r     (chain_win[k+1]),
      .tag_r     (chain_tag[k+1])
    );
  end

  assign push = chain_valid[CHAIN] && chain_tag[CHAIN].produce;
  assign drop = chain_valid[CHAIN] && !chain_tag[CHAIN].produce;

  always_comb begin
    push_beat.median_value = chain_win[CHAIN][mf3_pkg::WIN_MID];
    push_beat.center_row   = chain_tag[CHAIN].row;
    push_beat.center_col   = chain_tag[CHAIN].col;
    push_beat.frame_last   = chain_tag[CHAIN].last;
  end

  assign out_valid = (fifo_cnt_r != '0);
  assign out_data  = fifo_mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  assign occ_nxt = occ_r + (FIFO_AW + 1)'(accept) - (FIFO_AW + 1)'(pop)
                   - (FIFO_AW + 1)'(drop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      occ_r      <= '0;
    end else begin
      occ_r      <= occ_nxt;
      fifo_cnt_r <= fifo_cnt_r + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_beat;
    end
  end

endmodule

/* verif/median_filter_3x3_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Median filter 3x3 checker
// Watches the pixel, result and register ports of the filter, keeps its own
// line stores, window and raster position, queues the median due for every
// interior pixel beat and compares each result beat with the oldest one.
// ----------------------------------------------------------------------------
module median_filter_3x3_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  mf3_pkg::in_beat_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  mf3_pkg::out_beat_t            out_data,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [mf3_pkg::CFG_BITS-1:0]  cfg_data,
  output int                            mismatches,
  output int                            results_due
);

  mf3_pkg::pixel_t               upper_line [mf3_pkg::MAX_COLUMNS];
  mf3_pkg::pixel_t               middle_line [mf3_pkg::MAX_COLUMNS];
  mf3_pkg::pixel_t               window [mf3_pkg::WIN_SIZE];
  int                            col_pos;
  int                            row_pos;
  logic [mf3_pkg::COL_BITS:0]    columns_reg;
  logic [mf3_pkg::ROW_BITS-1:0]  rows_reg;
  mf3_pkg::out_beat_t            pending_medians [$];
  mf3_pkg::out_beat_t            oldest;

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // The median is the value with at most four samples below it and at least
  // five samples at or below it.
  function automatic mf3_pkg::pixel_t window_median();
    int              below;
    int              same;
    mf3_pkg::pixel_t pick;
    pick = '0;
    for (int i = 0; i < mf3_pkg::WIN_SIZE; i++) begin
      below = 0;
      same  = 0;
      for (int j = 0; j < mf3_pkg::WIN_SIZE; j++) begin
        if (window[j] < window[i]) begin
          below++;
        end else if (window[j] == window[i]) begin
          same++;
        end
      end
      if (below <= mf3_pkg::WIN_MID && below + same > mf3_pkg::WIN_MID) begin
        pick = window[i];
      end
    end
    return pick;
  endfunction

  task automatic slide_window(input mf3_pkg::in_beat_t beat);
    int                 cols;
    int                 rows;
    mf3_pkg::pixel_t    top_px;
    mf3_pkg::pixel_t    mid_px;
    mf3_pkg::out_beat_t due;
    if (columns_reg < 3) begin
      cols = 3;
    end else if (columns_reg > mf3_pkg::MAX_COLUMNS) begin
      cols = mf3_pkg::MAX_COLUMNS;
    end else begin
      cols = int'(columns_reg);
    end
    rows = (rows_reg < 3) ? 3 : int'(rows_reg);
    if (beat.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= cols) begin
      col_pos = 0;
    end
    if (row_pos >= rows) begin
      row_pos = 0;
    end
    top_px = upper_line[col_pos];
    mid_px = middle_line[col_pos];
    upper_line[col_pos]  = mid_px;
    middle_line[col_pos] = beat.pixel_value;
    for (int k = 0; k < 3; k++) begin
      window[3 * k]     = window[3 * k + 1];
      window[3 * k + 1] = window[3 * k + 2];
    end
    window[2] = top_px;
    window[5] = mid_px;
    window[8] = beat.pixel_value;
    if (row_pos >= 2 && col_pos >= 2) begin
      due.median_value = window_median();
      due.center_row   = mf3_pkg::ROW_BITS'(row_pos - 1);
      due.center_col   = mf3_pkg::COL_BITS'(col_pos - 1);
      due.frame_last   = (row_pos == rows - 1) && (col_pos == cols - 1);
      pending_medians.push_back(due);
    end
    if (col_pos + 1 >= cols) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      columns_reg = mf3_pkg::COLUMNS_RESET;
      rows_reg    = mf3_pkg::ROWS_RESET;
      col_pos     = 0;
      row_pos     = 0;
      for (int k = 0; k < mf3_pkg::WIN_SIZE; k++) begin
        window[k] = '0;
      end
      pending_medians.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_medians.size() == 0) begin
          note_mismatch("unexpected result beat, median", out_data.median_value, -1);
        end else begin
          oldest = pending_medians.pop_front();
          if (out_data.median_value !== oldest.median_value) begin
            note_mismatch("median_value", out_data.median_value, oldest.median_value);
          end
          if (out_data.center_row !== oldest.center_row) begin
            note_mismatch("center_row", out_data.center_row, oldest.center_row);
          end
          if (out_data.center_col !== oldest.center_col) begin
            note_mismatch("center_col", out_data.center_col, oldest.center_col);
          end
          if (out_data.frame_last !== oldest.frame_last) begin
            note_mismatch("frame_last", out_data.frame_last, oldest.frame_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        slide_window(in_data);
      end
      if (cfg_we) begin
        if (cfg_index == mf3_pkg::CFG_COLUMNS) begin
          columns_reg = cfg_data[mf3_pkg::COL_BITS:0];
        end else begin
          rows_reg = cfg_data[mf3_pkg::ROW_BITS-1:0];
        end
      end
    end
    results_due = pending_medians.size();
  end

endmodule

/* verif/median_filter_3x3_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Median filter 3x3 testbench
// Streams raster frames of many shapes into the filter: a few hand-picked
// frames, one frame that fills both line stores with geometry changes in the
// middle of a frame after it, then random frames under three idling mixes and
// one long hold-off of the result channel. The checker judges every result.
// ----------------------------------------------------------------------------
module median_filter_3x3_tb;

  localparam int HALF_PERIOD  = 6;
  localparam int QUIET_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int FILL_COLUMNS = 64;
  localparam int HIGH_BITS    = mf3_pkg::CFG_BITS - mf3_pkg::COL_BITS - 1;

  typedef enum int {PIX_FULL, PIX_LOW, PIX_EXTREME, PIX_HIGH} pix_style_t;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  mf3_pkg::in_beat_t            in_data   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  mf3_pkg::out_beat_t           out_data;
  logic                         cfg_we    = 1'b0;
  logic [0:0]                   cfg_index = mf3_pkg::CFG_COLUMNS;
  logic [mf3_pkg::CFG_BITS-1:0] cfg_data  = '0;
  int                           mismatches;
  int                           results_due;

  int                           send_idle_pct = 0;
  int                           recv_idle_pct = 0;
  pix_style_t                   pix_style     = PIX_FULL;
  int                           eff_cols      = 640;
  int                           eff_rows      = 480;
  logic                         hold_req      = 1'b0;
  logic                         hold_done     = 1'b0;
  int                           hold_left     = 0;
  mf3_pkg::pixel_t              probe_px [9]  = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128,
                                                  8'd127, 8'd255, 8'd0, 8'd255};

  always #HALF_PERIOD clk = ~clk;

  median_filter_3x3 u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  median_filter_3x3_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic mf3_pkg::pixel_t next_pixel();
    unique case (pix_style)
      PIX_LOW: begin
        return mf3_pkg::pixel_t'($urandom_range(3));
      end
      PIX_EXTREME: begin
        return $urandom_range(1) ? {mf3_pkg::PIXEL_BITS{1'b1}} :
                                   {mf3_pkg::PIXEL_BITS{1'b0}};
      end
      PIX_HIGH: begin
        return mf3_pkg::pixel_t'($urandom_range(255, 250));
      end
      default: begin
        return mf3_pkg::pixel_t'($urandom_range(255));
      end
    endcase
  endfunction

  // Entered and left at a falling edge; the beat stays put while stalled.
  task automatic send_pixel(input mf3_pkg::pixel_t pix, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pixel_value: pix, frame_start: fs};
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic send_pixels(input int count, input logic fs_first, input int restart_permille);
    for (int i = 0; i < count; i++) begin
      send_pixel(next_pixel(), (i == 0 && fs_first) ||
                 ($urandom_range(999) < restart_permille));
    end
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (results_due != 0) begin
      @(negedge clk);
    end
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic set_geometry(input logic [mf3_pkg::CFG_BITS-1:0] cols_word,
                              input logic [mf3_pkg::CFG_BITS-1:0] rows_word);
    int c;
    wait_for_idle();
    cfg_we    <= 1'b1;
    cfg_index <= mf3_pkg::CFG_COLUMNS;
    cfg_data  <= cols_word;
    @(negedge clk);
    cfg_index <= mf3_pkg::CFG_ROWS;
    cfg_data  <= rows_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    c = int'(cols_word[mf3_pkg::COL_BITS:0]);
    eff_cols = (c < 3) ? 3 : ((c > mf3_pkg::MAX_COLUMNS) ? mf3_pkg::MAX_COLUMNS : c);
    eff_rows = (rows_word < 3) ? 3 : int'(rows_word);
  endtask

  task automatic pick_geometry(output logic [mf3_pkg::CFG_BITS-1:0] cols_word,
                               output logic [mf3_pkg::CFG_BITS-1:0] rows_word);
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      cols_word = mf3_pkg::CFG_BITS'($urandom_range(2));
    end else if (roll < 16) begin
      cols_word = mf3_pkg::CFG_BITS'($urandom_range(FILL_COLUMNS, 17));
    end else begin
      cols_word = mf3_pkg::CFG_BITS'($urandom_range(16, 3));
    end
    if ($urandom_range(3) == 0) begin
      cols_word[mf3_pkg::CFG_BITS-1:mf3_pkg::COL_BITS+1] = HIGH_BITS'($urandom_range(31));
    end
    roll = $urandom_range(99);
    if (roll < 8) begin
      rows_word = mf3_pkg::CFG_BITS'($urandom_range(2));
    end else if (roll < 12) begin
      rows_word = {mf3_pkg::CFG_BITS{1'b1}};
    end else begin
      rows_word = mf3_pkg::CFG_BITS'($urandom_range(6, 3));
    end
  endtask

  task automatic random_stretch(input int target);
    int                           done_px;
    int                           span;
    int                           cut;
    logic                         fs;
    logic [mf3_pkg::CFG_BITS-1:0] cols_word;
    logic [mf3_pkg::CFG_BITS-1:0] rows_word;
    done_px = 0;
    while (done_px < target) begin
      pick_geometry(cols_word, rows_word);
      set_geometry(cols_word, rows_word);
      repeat ($urandom_range(3, 1)) begin
        if ($urandom_range(99) < 60) begin
          pix_style = PIX_FULL;
        end else begin
          pix_style = pix_style_t'($urandom_range(3));
        end
        span = eff_cols * eff_rows;
        if (span > 400) begin
          span = eff_cols * $urandom_range(5, 2);
        end
        if ($urandom_range(9) == 0) begin
          span = $urandom_range(span - 1, 1);
        end
        fs = ($urandom_range(3) != 0);
        if ($urandom_range(9) == 0) begin
          cut = $urandom_range(span - 1, 1);
          send_pixels(cut, fs, 10);
          pick_geometry(cols_word, rows_word);
          set_geometry(cols_word, rows_word);
          send_pixels(span - cut, 1'b0, 10);
        end else begin
          send_pixels(span, fs, 10);
        end
        done_px += span;
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 76;
    set_geometry(16'd3, 16'd3);
    for (int i = 0; i < 9; i++) begin
      send_pixel(probe_px[i], i == 0);
    end
    // Register values below the minimum; the next frame follows without a
    // frame start, then a frame start cuts it short.
    set_geometry(16'd0, 16'd2);
    pix_style = PIX_EXTREME;
    send_pixels(4, 1'b0, 0);
    send_pixels(9, 1'b1, 0);

    // Three full rows at the longest row length used later fill both line
    // stores for every column before any row length grows within a frame.
    pix_style = PIX_FULL;
    set_geometry(mf3_pkg::CFG_BITS'(FILL_COLUMNS), 16'd3);
    send_pixels(3 * FILL_COLUMNS, 1'b1, 0);
    set_geometry(16'd3, 16'hFFFF);
    send_pixels(3, 1'b0, 0);
    set_geometry(16'd3, 16'd4);
    send_pixels(17, 1'b0, 0);
    set_geometry(16'd10, 16'd4);
    send_pixels(28, 1'b0, 0);

    random_stretch(220);
    send_idle_pct = 76;
    recv_idle_pct = 32;
    random_stretch(220);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // The result side holds off while pixel beats keep coming.
    pix_style = PIX_FULL;
    set_geometry(16'd16, 16'd40);
    hold_req <= 1'b1;
    send_pixels(220, 1'b1, 0);
    random_stretch(120);

    in_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && results_due != 0; n++) begin
      @(negedge clk);
    end
    repeat (QUIET_CYCLES) @(negedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
